// File: rtl/gcm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the grid cell maximum block.
// No dependencies; every other file but the checker uses this package.
package gcm_pkg;

  // Fixed field widths
  localparam int POS_W      = 10;
  localparam int ROW_W      = 11;
  localparam int GRID_W     = 7;
  localparam int SUM_W      = 22;
  localparam int CNT_W      = 13;
  localparam int CELL_DEPTH = 1024;
  localparam int CELL_AW    = 10;
  localparam int OX_W       = 7;

  // Shared divider: dividend, divisor and step counter widths
  localparam int DIV_NW  = 24;
  localparam int DIV_DW  = 14;
  localparam int DIV_CW  = 5;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_SIZE     = 3'd0,
    REG_REGION_LEFT   = 3'd1,
    REG_REGION_RIGHT  = 3'd2,
    REG_REGION_TOP    = 3'd3,
    REG_REGION_BOTTOM = 3'd4,
    REG_IMAGE_ROWS    = 3'd5
  } cfg_reg_t;

  localparam logic [GRID_W-1:0] GRID_RESET   = 7'd8;
  localparam logic [POS_W-1:0]  LEFT_RESET   = 10'd0;
  localparam logic [POS_W-1:0]  RIGHT_RESET  = 10'd1023;
  localparam logic [POS_W-1:0]  TOP_RESET    = 10'd0;
  localparam logic [POS_W-1:0]  BOTTOM_RESET = 10'd1023;
  localparam logic [ROW_W-1:0]  ROWS_RESET   = 11'd1024;

  // Divider operand selection
  typedef enum logic [1:0] {
    DIV_COL  = 2'd0,
    DIV_ROW  = 2'd1,
    DIV_MCOL = 2'd2,
    DIV_MROW = 2'd3
  } div_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RANGE,
    ST_DIV_COL,
    ST_DIV_ROW,
    ST_CHECK,
    ST_UPDATE,
    ST_EMIT,
    ST_DIV_MCOL,
    ST_DIV_MROW,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_t start_sel;
    logic     cap_col;
    logic     cap_row;
    logic     cap_mcol;
    logic     cap_mrow;
    logic     mem_rd;
    logic     mem_wr;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic in_region;
    logic cell_full;
    logic emit;
    logic div_done;
    logic out_free;
  } stat_t;

endpackage

// File: rtl/gcm_divider.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// Depends on gcm_pkg for widths.
module gcm_divider (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [gcm_pkg::DIV_NW-1:0]  dividend,
  input  logic [gcm_pkg::DIV_DW-1:0]  divisor,
  output logic                        done,
  output logic [gcm_pkg::DIV_NW-1:0]  quotient,
  output logic [gcm_pkg::DIV_DW-1:0]  remainder
);
  import gcm_pkg::*;

  logic              busy;
  logic [DIV_CW-1:0] count;
  logic [DIV_DW-1:0] dvsr;
  logic [DIV_DW:0]   shifted;
  logic [DIV_DW:0]   trial;

  // Shift in the next dividend bit and try a subtract
  always_comb begin
    shifted = {remainder, quotient[DIV_NW-1]};
    trial   = shifted - {1'b0, dvsr};
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == DIV_CW'(DIV_NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dvsr      <= divisor;
    end else if (busy) begin
      if (!trial[DIV_DW]) begin
        remainder <= trial[DIV_DW-1:0];
        quotient  <= {quotient[DIV_NW-2:0], 1'b1};
      end else begin
        remainder <= shifted[DIV_DW-1:0];
        quotient  <= {quotient[DIV_NW-2:0], 1'b0};
      end
    end
  end

endmodule

// File: rtl/gcm_datapath.sv
`timescale 1ns / 1ps
// Datapath: configuration registers, position tracking, cell store, divider
// and output register. Depends on gcm_pkg and gcm_divider.
module gcm_datapath #(
  parameter int MAX_ROWS    = 1024,
  parameter int MAX_GRID    = 64,
  parameter int SAMPLE_BITS = 32,
  parameter int S_W         = 32,
  parameter int M_W         = 72
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [gcm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gcm_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [S_W-1:0]                  s_tdata,
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [M_W-1:0]                  m_tdata,
  output logic                            m_tlast,
  input  gcm_pkg::cmd_t                   cmd,
  output gcm_pkg::stat_t                  stat
);
  import gcm_pkg::*;

  localparam int ENT_W = SAMPLE_BITS + 2 * SUM_W + CNT_W;
  localparam int EXT_W = 20;

  // Configuration registers
  logic [GRID_W-1:0] grid_size;
  logic [POS_W-1:0]  region_left, region_right, region_top, region_bottom;
  logic [ROW_W-1:0]  image_rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size     <= GRID_RESET;
      region_left   <= LEFT_RESET;
      region_right  <= RIGHT_RESET;
      region_top    <= TOP_RESET;
      region_bottom <= BOTTOM_RESET;
      image_rows    <= ROWS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GRID_SIZE:     grid_size     <= cfg_data[GRID_W-1:0];
        REG_REGION_LEFT:   region_left   <= cfg_data[POS_W-1:0];
        REG_REGION_RIGHT:  region_right  <= cfg_data[POS_W-1:0];
        REG_REGION_TOP:    region_top    <= cfg_data[POS_W-1:0];
        REG_REGION_BOTTOM: region_bottom <= cfg_data[POS_W-1:0];
        REG_IMAGE_ROWS:    image_rows    <= cfg_data[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the registers to usable values
  logic [GRID_W-1:0] g0, g_eff;
  logic [ROW_W-1:0]  rows0, rows_eff, bottom_eff;

  always_comb begin
    g0    = (grid_size == '0) ? GRID_W'(1) : grid_size;
    g_eff = (int'(g0) > MAX_GRID) ? GRID_W'(MAX_GRID) : g0;
    rows0 = (image_rows == '0) ? ROW_W'(1) : image_rows;
    rows_eff = (int'(rows0) > MAX_ROWS) ? ROW_W'(MAX_ROWS) : rows0;
    bottom_eff = (ROW_W'(region_bottom) > rows_eff - 1'b1)
               ? rows_eff - 1'b1 : ROW_W'(region_bottom);
  end

  // Position of the next sample and of the current one
  logic [POS_W-1:0]       col_pos, cur_c, c_in;
  logic [ROW_W-1:0]       row_pos, cur_r, r_in;
  logic [SAMPLE_BITS-1:0] samp;

  always_comb begin
    c_in = s_tuser ? '0 : col_pos;
    r_in = s_tuser ? '0 : row_pos;
    if (r_in >= rows_eff) r_in = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos <= '0;
      row_pos <= '0;
    end else if (cmd.load) begin
      if (12'(r_in) + 12'd1 >= 12'(rows_eff)) begin
        row_pos <= '0;
        col_pos <= c_in + 1'b1;
      end else begin
        row_pos <= r_in + 1'b1;
        col_pos <= c_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_c <= c_in;
      cur_r <= r_in;
      samp  <= s_tdata[SAMPLE_BITS-1:0];
    end
  end

  // Shared divider and its operands
  logic [SUM_W-1:0]       ent_csum, ent_rsum;
  logic [CNT_W-1:0]       ent_cnt;
  logic [SAMPLE_BITS-1:0] ent_max;
  logic [DIV_NW-1:0]      div_n, div_q;
  logic [DIV_DW-1:0]      div_d, div_r;
  logic                   div_done;

  always_comb begin
    case (cmd.start_sel)
      DIV_COL: begin
        div_n = DIV_NW'(cur_c - region_left);
        div_d = DIV_DW'(g_eff);
      end
      DIV_ROW: begin
        div_n = DIV_NW'(cur_r - ROW_W'(region_top));
        div_d = DIV_DW'(g_eff);
      end
      DIV_MCOL: begin
        div_n = DIV_NW'({ent_csum, 1'b0}) + DIV_NW'(ent_cnt);
        div_d = {ent_cnt, 1'b0};
      end
      DIV_MROW: begin
        div_n = DIV_NW'({ent_rsum, 1'b0}) + DIV_NW'(ent_cnt);
        div_d = {ent_cnt, 1'b0};
      end
      default: begin
        div_n = '0;
        div_d = '0;
      end
    endcase
  end

  gcm_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (div_n),
    .divisor   (div_d),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // Capture cell indexes, offsets and rounded means
  logic [POS_W-1:0] cx, mcol, mrow;
  logic [ROW_W-1:0] cy;
  logic [OX_W-1:0]  ox, oy;

  always_ff @(posedge clk) begin
    if (cmd.cap_col) begin
      cx <= div_q[POS_W-1:0];
      ox <= div_r[OX_W-1:0];
    end
    if (cmd.cap_row) begin
      cy <= div_q[ROW_W-1:0];
      oy <= div_r[OX_W-1:0];
    end
    if (cmd.cap_mcol) mcol <= div_q[POS_W-1:0];
    if (cmd.cap_mrow) mrow <= div_q[POS_W-1:0];
  end

  // Region and cell bounds
  logic [EXT_W-1:0] col_end, row_end;
  logic [GRID_W-1:0] g_last;

  always_comb begin
    col_end = EXT_W'(region_left) + EXT_W'(cx) * EXT_W'(g_eff) + EXT_W'(g_eff);
    row_end = EXT_W'(region_top) + EXT_W'(cy) * EXT_W'(g_eff) + EXT_W'(g_eff);
    g_last  = g_eff - 1'b1;
    stat.in_region = (cur_c >= region_left) && (cur_c <= region_right) &&
                     (cur_r >= ROW_W'(region_top)) && (cur_r <= bottom_eff);
    stat.cell_full = (col_end <= EXT_W'(region_right) + 1'b1) &&
                     (row_end <= EXT_W'(bottom_eff) + 1'b1);
    stat.emit      = (ox == g_last) && (oy == g_last);
    stat.div_done  = div_done;
    stat.out_free  = !m_tvalid || m_tready;
  end

  // Cell store, one entry per cell row index
  logic [ENT_W-1:0]       mem [CELL_DEPTH];
  logic [ENT_W-1:0]       rd, ent_next;
  logic [SAMPLE_BITS-1:0] rd_max;
  logic [SUM_W-1:0]       rd_csum, rd_rsum;
  logic [CNT_W-1:0]       rd_cnt;

  always_ff @(posedge clk) begin
    if (cmd.mem_rd) rd <= mem[cy[CELL_AW-1:0]];
    if (cmd.mem_wr) mem[cy[CELL_AW-1:0]] <= ent_next;
  end

  // Restart on first pixel or new maximum, accumulate on a tie
  always_comb begin
    {rd_max, rd_csum, rd_rsum, rd_cnt} = rd;
    if (((ox == '0) && (oy == '0)) || ($signed(samp) > $signed(rd_max))) begin
      ent_next = {samp, SUM_W'(cur_c), SUM_W'(cur_r), CNT_W'(1)};
    end else if (samp == rd_max) begin
      ent_next = {rd_max, rd_csum + SUM_W'(cur_c), rd_rsum + SUM_W'(cur_r),
                  rd_cnt + 1'b1};
    end else begin
      ent_next = rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) {ent_max, ent_csum, ent_rsum, ent_cnt} <= ent_next;
  end

  // Output register
  logic last_cell;

  assign last_cell = (12'(cur_c) + 12'(g_eff) > 12'(region_right)) &&
                     (12'(cur_r) + 12'(g_eff) > 12'(bottom_eff));

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= M_W'({cy[POS_W-1:0], cx, mrow, mcol, ent_max});
      m_tlast <= last_cell;
    end
  end

endmodule

// File: rtl/gcm_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences one pixel through range check, index division,
// cell update and result division. Depends on gcm_pkg.
module gcm_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  gcm_pkg::stat_t  stat,
  output gcm_pkg::cmd_t   cmd
);
  import gcm_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (s_tvalid) state_next = ST_RANGE;
      ST_RANGE:    state_next = stat.in_region ? ST_DIV_COL : ST_IDLE;
      ST_DIV_COL:  if (stat.div_done) state_next = ST_DIV_ROW;
      ST_DIV_ROW:  if (stat.div_done) state_next = ST_CHECK;
      ST_CHECK:    state_next = stat.cell_full ? ST_UPDATE : ST_IDLE;
      ST_UPDATE:   state_next = stat.emit ? ST_EMIT : ST_IDLE;
      ST_EMIT:     state_next = ST_DIV_MCOL;
      ST_DIV_MCOL: if (stat.div_done) state_next = ST_DIV_MROW;
      ST_DIV_MROW: if (stat.div_done) state_next = ST_OUT;
      ST_OUT:      if (stat.out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd = '0;
    cmd.start_sel = DIV_COL;
    s_tready = (state == ST_IDLE);
    case (state)
      ST_IDLE:  cmd.load = s_tvalid;
      ST_RANGE: cmd.div_start = stat.in_region;
      ST_DIV_COL: begin
        cmd.cap_col   = stat.div_done;
        cmd.div_start = stat.div_done;
        cmd.start_sel = DIV_ROW;
      end
      ST_DIV_ROW: cmd.cap_row = stat.div_done;
      ST_CHECK:   cmd.mem_rd = stat.cell_full;
      ST_UPDATE:  cmd.mem_wr = 1'b1;
      ST_EMIT: begin
        cmd.div_start = 1'b1;
        cmd.start_sel = DIV_MCOL;
      end
      ST_DIV_MCOL: begin
        cmd.cap_mcol  = stat.div_done;
        cmd.div_start = stat.div_done;
        cmd.start_sel = DIV_MROW;
      end
      ST_DIV_MROW: cmd.cap_mrow = stat.div_done;
      ST_OUT:      cmd.out_load = stat.out_free;
      default: ;
    endcase
  end

endmodule

// File: rtl/grid_cell_max_with_tie_centroid.sv
`timescale 1ns / 1ps
// Top level of the grid cell maximum block: controller plus datapath.
// Depends on gcm_pkg, gcm_ctrl and gcm_datapath.
//
// Usage: pixels arrive column-major on the slave stream, one request per
// pixel; s_tuser marks the first pixel of an image. The region set on the
// configuration port is cut into square cells of grid_size pixels; partial
// cells at the right and bottom are skipped. When the last pixel of a full
// cell is taken, one result leaves on the master stream: the cell maximum,
// the rounded mean column and row of all pixels equal to it, and the cell
// indexes; m_tlast flags the last cell of the region.
// Timing: one pixel is in flight at a time. A pixel inside the region uses
// the shared divider twice, for its cell indexes; a cell-closing pixel uses
// it twice more, for the rounded means, and then waits until the output
// register is free.
// Reset clears the position to column 0, row 0 and loads the register
// defaults; the cell store is not cleared, as every cell starts on its first
// pixel. A result waits in the output register while the receiver stalls and
// the next pixel is still taken; a second result holds until the first goes.
module grid_cell_max_with_tie_centroid #(
  parameter int MAX_ROWS    = 1024,
  parameter int MAX_GRID    = 64,
  parameter int SAMPLE_BITS = 32,
  localparam int S_W = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int M_W = ((SAMPLE_BITS + 40 + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [gcm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gcm_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [S_W-1:0]                  s_tdata,  // sample
  input  logic                            s_tuser,  // frame_start
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // max_value, peak_column, peak_row, cell_column, cell_row
  output logic [M_W-1:0]                  m_tdata,
  output logic                            m_tlast   // region_done
);
  import gcm_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  gcm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  gcm_datapath #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_GRID    (MAX_GRID),
    .SAMPLE_BITS (SAMPLE_BITS),
    .S_W         (S_W),
    .M_W         (M_W)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// File: rtl/gcm_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the grid cell maximum block, bound to the top level.
// Depends only on the top level's ports.
module gcm_checker (
  input logic clk,
  input logic rst,
  input logic s_tvalid,
  input logic s_tready,
  input logic m_tvalid,
  input logic m_tready,
  input logic m_tlast
);

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tlast))
    else $error("stalled result dropped or changed");

  // One pixel at a time: intake closes after each request
  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("pixel taken while another is in work");

  // A new result is loaded only while intake is closed
  a_load_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result appeared without work in progress");

endmodule

bind grid_cell_max_with_tie_centroid gcm_checker u_gcm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tlast  (m_tlast)
);

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for grid_cell_max_with_tie_centroid: streams pixel frames,
// predicts every cell maximum and tie centroid, and compares each result.
// Depends on gcm_pkg and the block's RTL.
module tb_top;
  import gcm_pkg::*;

  localparam int LIMIT_CYCLES = 2000000;
  localparam int DRAIN_CYCLES = 300;

  typedef struct {
    logic [31:0] max_value;
    logic [9:0]  peak_column;
    logic [9:0]  peak_row;
    logic [9:0]  cell_column;
    logic [9:0]  cell_row;
    logic        region_done;
  } cell_result_t;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic              s_tvalid;
  logic              s_tready;
  logic [31:0]       s_tdata;   // sample
  logic              s_tuser;   // frame_start
  logic              m_tvalid;
  logic              m_tready;
  // max_value, peak_column, peak_row, cell_column, cell_row
  logic [71:0]       m_tdata;
  logic              m_tlast;   // region_done

  grid_cell_max_with_tie_centroid dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  // Predictor state: registers, position and per-row cell store
  int unsigned grid_q, left_q, right_q, top_q, bottom_q, rows_q;
  int unsigned col_pos, row_pos;
  logic [31:0] cell_max [CELL_DEPTH];
  int unsigned col_sum [CELL_DEPTH];
  int unsigned row_sum [CELL_DEPTH];
  int unsigned hit_cnt [CELL_DEPTH];

  cell_result_t pending_cells[$];
  int  errors;
  int  cycles;
  bit  pixel_taken;
  bit  hold_req;
  int  burst_left;
  int  stall_pct;

  // Clock and cycle limit
  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Flag a taken request for the sender, sampled at the edge
  always @(posedge clk) pixel_taken <= s_tvalid && s_tready && !rst;

  function automatic int unsigned rounded_mean(int unsigned sum, int unsigned cnt);
    if (cnt == 0) return 0;
    return int'(((longint'(sum) * 2 + cnt) / (longint'(cnt) * 2)) & 1023);
  endfunction

  // Track position and cell store for one pixel; queue a result on cell close
  task automatic predict_pixel(input logic [31:0] s, input logic fs);
    int unsigned g, rows, bottom, c, r, cx, cy, ox, oy, idx;
    cell_result_t res;
    g = grid_q;
    if (g == 0) g = 1;
    if (g > 64) g = 64;
    rows = rows_q;
    if (rows == 0) rows = 1;
    if (rows > 1024) rows = 1024;
    bottom = (bottom_q > rows - 1) ? rows - 1 : bottom_q;
    if (fs) begin
      c = 0; r = 0;
    end else begin
      c = col_pos; r = row_pos;
    end
    if (r >= rows) r = 0;
    if (r + 1 >= rows) begin
      row_pos = 0; col_pos = (c + 1) & 1023;
    end else begin
      row_pos = r + 1; col_pos = c;
    end
    if (c < left_q || c > right_q || r < top_q || r > bottom) return;
    cx = (c - left_q) / g; ox = (c - left_q) % g;
    cy = (r - top_q) / g;  oy = (r - top_q) % g;
    if (left_q + (cx + 1) * g - 1 > right_q) return;
    if (top_q + (cy + 1) * g - 1 > bottom) return;
    idx = cy & 1023;
    if ((ox == 0 && oy == 0) || $signed(s) > $signed(cell_max[idx])) begin
      cell_max[idx] = s; col_sum[idx] = c; row_sum[idx] = r; hit_cnt[idx] = 1;
    end else if (s == cell_max[idx]) begin
      col_sum[idx] = (col_sum[idx] + c) & 22'h3FFFFF;
      row_sum[idx] = (row_sum[idx] + r) & 22'h3FFFFF;
      hit_cnt[idx] = (hit_cnt[idx] + 1) & 13'h1FFF;
    end
    if (!(ox == g - 1 && oy == g - 1)) return;
    res.max_value   = cell_max[idx];
    res.peak_column = 10'(rounded_mean(col_sum[idx], hit_cnt[idx]));
    res.peak_row    = 10'(rounded_mean(row_sum[idx], hit_cnt[idx]));
    res.cell_column = 10'(cx);
    res.cell_row    = 10'(cy);
    res.region_done = (c + g > right_q && r + g > bottom);
    pending_cells.insert(pending_cells.size(), res);
  endtask

  // Compare each taken result with the oldest prediction
  always @(posedge clk) begin
    cell_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_cells.size() == 0) begin
        $error("unexpected result: max_value %h", m_tdata[31:0]);
        errors++;
      end else begin
        want = pending_cells.pop_front();
        if (m_tdata[31:0] !== want.max_value) begin
          $error("max_value expected %h got %h", want.max_value, m_tdata[31:0]); errors++;
        end
        if (m_tdata[41:32] !== want.peak_column) begin
          $error("peak_column expected %0d got %0d", want.peak_column, m_tdata[41:32]);
          errors++;
        end
        if (m_tdata[51:42] !== want.peak_row) begin
          $error("peak_row expected %0d got %0d", want.peak_row, m_tdata[51:42]); errors++;
        end
        if (m_tdata[61:52] !== want.cell_column) begin
          $error("cell_column expected %0d got %0d", want.cell_column, m_tdata[61:52]);
          errors++;
        end
        if (m_tdata[71:62] !== want.cell_row) begin
          $error("cell_row expected %0d got %0d", want.cell_row, m_tdata[71:62]); errors++;
        end
        if (m_tlast !== want.region_done) begin
          $error("region_done expected %0d got %0d", want.region_done, m_tlast); errors++;
        end
      end
    end
  end

  // Receiver: random stall pattern with changing density, long hold on request
  initial begin
    int span;
    m_tready = 0;
    stall_pct = 0;
    span = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready = 0;
        repeat (3000) @(negedge clk);
        hold_req = 0;
      end else begin
        if (span == 0) begin
          span = $urandom_range(50, 400);
          case ($urandom_range(0, 2))
            0: stall_pct = 0;
            1: stall_pct = 30;
            default: stall_pct = 80;
          endcase
        end
        span--;
        m_tready = ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Offer one pixel request, idling between bursts, and predict it once taken
  task automatic send_pixel(input logic [31:0] s, input logic fs);
    if (burst_left == 0) begin
      s_tvalid = 0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_tvalid = 1;
    s_tdata  = s;
    s_tuser  = fs;
    do begin
      @(posedge clk);
      @(negedge clk);
    end while (!pixel_taken);
    predict_pixel(s, fs);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int unsigned val);
    cfg_we = 1; cfg_index = idx; cfg_data = val[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we = 0;
    case (idx)
      REG_GRID_SIZE:     grid_q   = val & 127;
      REG_REGION_LEFT:   left_q   = val & 1023;
      REG_REGION_RIGHT:  right_q  = val & 1023;
      REG_REGION_TOP:    top_q    = val & 1023;
      REG_REGION_BOTTOM: bottom_q = val & 1023;
      REG_IMAGE_ROWS:    rows_q   = val & 2047;
      default: ;
    endcase
  endtask

  // Wait until every predicted result is out, then let the block settle
  task automatic drain();
    s_tvalid = 0;
    while (pending_cells.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic setup(input int unsigned g, l, rt, t, b, rows);
    drain();
    write_reg(REG_GRID_SIZE, g);
    write_reg(REG_REGION_LEFT, l);
    write_reg(REG_REGION_RIGHT, rt);
    write_reg(REG_REGION_TOP, t);
    write_reg(REG_REGION_BOTTOM, b);
    write_reg(REG_IMAGE_ROWS, rows);
  endtask

  function automatic logic [31:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0001_0000;
      3: return $urandom_range(0, 3);
      default: return $urandom();
    endcase
  endfunction

  // Reset defaults take pixels without a finished cell
  task automatic test_reset_defaults();
    send_pixel(32'h7FFF_FFFF, 1);
    send_pixel(32'h8000_0000, 0);
    send_pixel(32'h0000_0000, 0);
  endtask

  // Grid of one with zero rows: every pixel its own column, cells in the region
  task automatic test_single_pixel_cells();
    setup(0, 0, 3, 0, 0, 0);
    send_pixel(32'h8000_0000, 1);
    send_pixel(32'h7FFF_FFFF, 0);
    send_pixel(32'hFFFF_FFFF, 0);
    for (int i = 3; i < 40; i++) send_pixel($urandom(), 0);
  endtask

  // Ties of extreme values in a 2x2 cell, and a strictly larger value restarting them
  task automatic test_ties();
    setup(2, 1, 4, 1, 4, 6);
    for (int i = 0; i < 36; i++)
      send_pixel((i % 3 == 0) ? 32'h7FFF_FFFF : ((i % 3 == 1) ? 32'h8000_0000 : 32'h5),
                 i == 0);
    for (int i = 0; i < 36; i++) send_pixel(32'h8000_0000, i == 0);
  endtask

  // Oversized grid, rows above the maximum, empty regions, bottom past the image
  task automatic test_clamps_and_empty();
    setup(127, 0, 1023, 0, 1023, 2047);
    for (int i = 0; i < 5; i++) send_pixel($urandom(), i == 0);
    setup(1, 5, 2, 0, 3, 4);
    for (int i = 0; i < 8; i++) send_pixel($urandom(), i == 0);
    setup(1, 0, 3, 3, 1, 4);
    for (int i = 0; i < 8; i++) send_pixel($urandom(), i == 0);
    setup(2, 0, 3, 1, 1023, 6);
    for (int i = 0; i < 24; i++) send_pixel(pick_sample(), i == 0);
  endtask

  // Long receiver hold while pixels keep coming: the block must stall its input
  task automatic test_backpressure();
    setup(1, 0, 7, 0, 3, 4);
    hold_req = 1;
    for (int i = 0; i < 32; i++) send_pixel($urandom(), i == 0);
  endtask

  // Random configurations with mostly whole frames, some broken by early restarts
  task automatic test_random_frames();
    int sent;
    int unsigned g, rows, t, b, l, rt, cols, n;
    sent = 0;
    while (sent < 300) begin
      g = $urandom_range(1, 4);
      rows = $urandom_range(g, 12);
      t = $urandom_range(0, 2);
      b = t + $urandom_range(0, rows + 2);
      l = $urandom_range(0, 2);
      rt = l + $urandom_range(g - 1, 8);
      setup(g, l, rt, t, b, rows);
      cols = rt + 1 + $urandom_range(0, 1);
      for (int f = 0; f < 2; f++) begin
        n = rows * cols;
        for (int i = 0; i < n; i++) begin
          if (i != 0 && $urandom_range(0, 99) == 0) begin
            send_pixel(pick_sample(), 1);
            sent++;
            break;
          end
          send_pixel(pick_sample(), i == 0);
          sent++;
        end
      end
    end
  endtask

  initial begin
    rst = 1;
    cfg_we = 0; cfg_index = REG_GRID_SIZE; cfg_data = '0;
    s_tvalid = 0; s_tdata = '0; s_tuser = 0;
    hold_req = 0; burst_left = 0; errors = 0; cycles = 0;
    grid_q = GRID_RESET; left_q = LEFT_RESET; right_q = RIGHT_RESET;
    top_q = TOP_RESET; bottom_q = BOTTOM_RESET; rows_q = ROWS_RESET;
    col_pos = 0; row_pos = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 0;
    test_reset_defaults();
    test_single_pixel_cells();
    test_ties();
    test_clamps_and_empty();
    test_backpressure();
    test_random_frames();
    drain();
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/gcm_pkg.sv
rtl/gcm_divider.sv
rtl/gcm_datapath.sv
rtl/gcm_ctrl.sv
rtl/grid_cell_max_with_tie_centroid.sv
rtl/gcm_checker.sv
tb/tb_top.sv
